FILE: hw/rtl/lms_adaptive_fir_assert.svh
// Assertion macros shared by the adaptive filter RTL files.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef LMS_ADAPTIVE_FIR_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_ASSERT_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge out of reset.
`define LMSAF_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lmsaf assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define LMSAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmsaf assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define LMSAF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmsaf assertion failed");
`else
`define LMSAF_ASSERT(label, clk, rst_n, expr)
`define LMSAF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LMSAF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/lmsaf_pkg.sv
// Package for the LMS adaptive FIR: field widths, constants and the
// sequencer-to-datapath control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmsaf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 48;
    localparam int PROD_W   = 64;
    localparam int OUT_W    = 32;
    localparam int MU_W     = 6;

    localparam logic [MU_W-1:0] MU_RESET = 6'd5;

    // Control flags driven by the sequencer.
    typedef struct packed {
        logic clr;       // clearing pass: zero both memories at w_addr
        logic accept;    // item taken: write reference sample at d_addr
        logic rd_en;     // issue a tap read at w_addr / d_addr
        logic rd_last;   // this read is the final tap of the pass
        logic upd;       // pass is the weight update, not the filter sum
        logic fin;       // form output and error from the accumulator
        logic load_out;  // move the result into the output register
    } lmsaf_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lmsaf_mul.sv
// Shared signed multiplier with a registered product, 48 by 16 bits.
// Depends on lmsaf_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module lmsaf_mul (
    input  wire                                   aclk,
    input  wire logic signed [lmsaf_pkg::WEIGHT_W-1:0] a,
    input  wire logic signed [lmsaf_pkg::SAMPLE_W-1:0] b,
    output logic signed [lmsaf_pkg::PROD_W-1:0]   prod
);
    import lmsaf_pkg::*;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;

    // Both operands are signed, so they are sign extended to the product width.
    assign prod_next = a * b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lmsaf_seq.sv
// Sequencer of the adaptive filter: clearing pass, filter pass, weight
// update pass and delay line head pointer. Depends on lmsaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "lms_adaptive_fir_assert.svh"

module lmsaf_seq #(
    parameter int TAPS = 256
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           out_free,
    input  wire                           pass_done,
    output lmsaf_pkg::lmsaf_ctl_t         ctl,
    output logic [$clog2(TAPS)-1:0]       w_addr,
    output logic [$clog2(TAPS)-1:0]       d_addr
);
    import lmsaf_pkg::*;

    localparam int IDX_W = $clog2(TAPS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] daddr_reg, daddr_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             iss_on_reg, iss_on_next;

    // Next state and control flags.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        daddr_next  = daddr_reg;
        ptr_next    = ptr_reg;
        iss_on_next = iss_on_reg;
        ctl         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ctl.clr = 1'b1;
                if (cnt_reg == LAST) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.accept  = 1'b1;
                    cnt_next    = '0;
                    daddr_next  = ptr_reg;
                    iss_on_next = 1'b1;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC, ST_UPD: begin
                ctl.upd = (state_reg == ST_UPD);
                if (iss_on_reg) begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_last = (cnt_reg == LAST);
                    daddr_next  = (daddr_reg == LAST) ? '0 : daddr_reg + 1'b1;
                    if (cnt_reg == LAST) begin
                        iss_on_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (pass_done) begin
                    state_next = (state_reg == ST_MAC) ? ST_FIN : ST_DONE;
                end
            end
            ST_FIN: begin
                ctl.fin     = 1'b1;
                cnt_next    = '0;
                daddr_next  = ptr_reg;
                iss_on_next = 1'b1;
                state_next  = ST_UPD;
            end
            ST_DONE: begin
                if (out_free) begin
                    ctl.load_out = 1'b1;
                    // The delay line shifts by moving its head one place back.
                    ptr_next     = (ptr_reg == '0) ? LAST : ptr_reg - 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    assign w_addr = cnt_reg;
    assign d_addr = (state_reg == ST_IDLE) ? ptr_reg : daddr_reg;

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            daddr_reg  <= '0;
            ptr_reg    <= '0;
            iss_on_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            daddr_reg  <= daddr_next;
            ptr_reg    <= ptr_next;
            iss_on_reg <= iss_on_next;
        end
    end

    `LMSAF_ASSERT_IMP(a_done_in_pass, aclk, aresetn, pass_done, (state_reg == ST_MAC) || (state_reg == ST_UPD))
    `LMSAF_ASSERT(a_addr_in_range, aclk, aresetn, (ptr_reg <= LAST) && (daddr_reg <= LAST))
    `LMSAF_ASSERT_NXT(a_accept_starts, aclk, aresetn, ctl.accept, (state_reg == ST_MAC) && (cnt_reg == '0) && iss_on_reg)

endmodule

`default_nettype wire

FILE: hw/rtl/lmsaf_dp.sv
// Datapath of the adaptive filter: weight and delay memories, the tap
// pipeline around the shared multiplier, accumulator, saturation and
// weight update. Depends on lmsaf_pkg and lmsaf_mul.
`timescale 1ns / 1ps
`default_nettype none

module lmsaf_dp #(
    parameter int TAPS             = 256,
    parameter int WEIGHT_FRAC_BITS = 32
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire logic [lmsaf_pkg::MU_W-1:0]            mu_shift,
    input  wire logic signed [lmsaf_pkg::SAMPLE_W-1:0] in_desired,
    input  wire logic signed [lmsaf_pkg::SAMPLE_W-1:0] in_reference,
    input  wire lmsaf_pkg::lmsaf_ctl_t                 ctl,
    input  wire logic [$clog2(TAPS)-1:0]               w_addr,
    input  wire logic [$clog2(TAPS)-1:0]               d_addr,
    output logic                                       pass_done,
    output logic signed [lmsaf_pkg::OUT_W-1:0]         y_out,
    output logic signed [lmsaf_pkg::OUT_W-1:0]         e_out
);
    import lmsaf_pkg::*;

    localparam int IDX_W = $clog2(TAPS);
    localparam int ACC_W = PROD_W + IDX_W;
    localparam logic signed [ACC_W-1:0] ACC_Y_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] ACC_Y_MIN = ACC_W'(-64'sh0000_0000_8000_0000);
    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -32'sh8000_0000;
    localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    logic signed [WEIGHT_W-1:0] weight_mem [TAPS];
    logic signed [SAMPLE_W-1:0] delay_mem  [TAPS];

    logic signed [WEIGHT_W-1:0] w_rd_reg;
    logic signed [SAMPLE_W-1:0] d_rd_reg;
    logic                       s1_vld_reg, s1_last_reg, s1_upd_reg;
    logic [IDX_W-1:0]           s1_waddr_reg;
    logic                       s2_vld_reg, s2_last_reg, s2_upd_reg;
    logic [IDX_W-1:0]           s2_waddr_reg;
    logic signed [WEIGHT_W-1:0] s2_w_reg;

    logic signed [WEIGHT_W-1:0] mul_a;
    logic signed [PROD_W-1:0]   prod;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] desired_reg;
    logic signed [OUT_W-1:0]    y_reg, e_reg;

    logic signed [ACC_W-1:0]    acc_shr;
    logic signed [OUT_W-1:0]    y_next, e_next;
    logic signed [OUT_W:0]      diff;
    logic signed [PROD_W-1:0]   delta;
    logic signed [WEIGHT_W:0]   w_sum;
    logic signed [WEIGHT_W-1:0] w_new;
    logic                       wb_en;

    // Weight memory: one write port shared by clearing and write-back.
    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            weight_mem[w_addr] <= '0;
        end else if (wb_en) begin
            weight_mem[s2_waddr_reg] <= w_new;
        end
        w_rd_reg <= weight_mem[w_addr];
    end

    // Delay line memory, addressed as a ring around the head pointer.
    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            delay_mem[w_addr] <= '0;
        end else if (ctl.accept) begin
            delay_mem[d_addr] <= in_reference;
        end
        d_rd_reg <= delay_mem[d_addr];
    end

    // Tap pipeline control: read, multiply, then accumulate or write back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= ctl.rd_en;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_last_reg  <= ctl.rd_last;
        s1_upd_reg   <= ctl.upd;
        s1_waddr_reg <= w_addr;
        s2_last_reg  <= s1_last_reg;
        s2_upd_reg   <= s1_upd_reg;
        s2_waddr_reg <= s1_waddr_reg;
        s2_w_reg     <= w_rd_reg;
    end

    // The filter pass multiplies weight by tap; the update pass error by tap.
    assign mul_a = s1_upd_reg ? WEIGHT_W'(e_reg) : w_rd_reg;

    lmsaf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (d_rd_reg),
        .prod (prod)
    );

    assign pass_done = s2_vld_reg && s2_last_reg;

    // Weight update: arithmetic shift of the product, add, saturate to 48 bits.
    assign delta = prod >>> mu_shift;
    assign w_sum = (WEIGHT_W+1)'(s2_w_reg) + (WEIGHT_W+1)'($signed(delta[WEIGHT_W-1:0]));
    always_comb begin
        if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
            w_new = w_sum[WEIGHT_W] ? W_MIN : W_MAX;
        end else begin
            w_new = w_sum[WEIGHT_W-1:0];
        end
    end
    assign wb_en = s2_vld_reg && s2_upd_reg;

    // Output: floor of the exact sum by the fraction bits, saturated.
    assign acc_shr = acc_reg >>> WEIGHT_FRAC_BITS;
    always_comb begin
        if (acc_shr > ACC_Y_MAX) begin
            y_next = OUT_MAX;
        end else if (acc_shr < ACC_Y_MIN) begin
            y_next = OUT_MIN;
        end else begin
            y_next = acc_shr[OUT_W-1:0];
        end
    end

    // Error: desired sample minus the saturated output, saturated again.
    assign diff = (OUT_W+1)'(desired_reg) - (OUT_W+1)'(y_next);
    always_comb begin
        if (diff[OUT_W] != diff[OUT_W-1]) begin
            e_next = diff[OUT_W] ? OUT_MIN : OUT_MAX;
        end else begin
            e_next = diff[OUT_W-1:0];
        end
    end

    // Accumulator and result registers.
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            acc_reg     <= '0;
            desired_reg <= in_desired;
        end else if (s2_vld_reg && !s2_upd_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end
        if (ctl.fin) begin
            y_reg <= y_next;
            e_reg <= e_next;
        end
    end

    assign y_out = y_reg;
    assign e_out = e_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lms_adaptive_fir.sv
// Top level of the LMS adaptive FIR: stream ports, step size register and
// output register. Depends on lmsaf_pkg, lmsaf_seq and lmsaf_dp.
//
//   Channel   Direction  Handshake          Contents
//   s_        in         s_tvalid/s_tready  desired and reference sample
//   m_        out        m_tvalid/m_tready  filter output and error
//   cfg_      in         cfg_valid/ready    mu_shift
//
// From acceptance to the result register an item makes two passes over the taps
// through the one shared multiplier (filter sum and weight update, each a read of
// every tap plus the drain of the tap pipeline), forms the output and error in
// between and then loads the result. The next item can be taken in the cycle after
// the result is loaded. After reset a clearing pass zeroes both memories. A result held
// by m_tready low stalls the next item only once that item needs the register.
`timescale 1ns / 1ps
`default_nettype none
`include "lms_adaptive_fir_assert.svh"

module lms_adaptive_fir #(
    parameter int TAPS             = 256,
    parameter int WEIGHT_FRAC_BITS = 32
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [31:0] s_tdata,    // desired_sample [15:0], reference_sample [31:16]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [63:0] m_tdata,   // filter_output [31:0], error_value [63:32]
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [5:0]  cfg_data    // mu_shift
);
    import lmsaf_pkg::*;

    localparam int IDX_W = $clog2(TAPS);

    lmsaf_ctl_t              ctl;
    logic [IDX_W-1:0]        w_addr, d_addr;
    logic                    pass_done;
    logic                    out_free;
    logic signed [OUT_W-1:0] y_out, e_out;
    logic [MU_W-1:0]         mu_shift_reg;
    logic                    m_tvalid_reg;
    logic [2*OUT_W-1:0]      m_tdata_reg;

    // Step size register; writes are always taken.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_shift_reg <= MU_RESET;
        end else if (cfg_valid) begin
            mu_shift_reg <= cfg_data;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    lmsaf_seq #(
        .TAPS (TAPS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_free  (out_free),
        .pass_done (pass_done),
        .ctl       (ctl),
        .w_addr    (w_addr),
        .d_addr    (d_addr)
    );

    lmsaf_dp #(
        .TAPS             (TAPS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mu_shift     (mu_shift_reg),
        .in_desired   ($signed(s_tdata[15:0])),
        .in_reference ($signed(s_tdata[31:16])),
        .ctl          (ctl),
        .w_addr       (w_addr),
        .d_addr       (d_addr),
        .pass_done    (pass_done),
        .y_out        (y_out),
        .e_out        (e_out)
    );

    // Output register between the datapath and the result stream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            m_tdata_reg <= {e_out, y_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LMSAF_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `LMSAF_ASSERT_IMP(a_result_at_end, aclk, aresetn, $rose(m_tvalid), s_tready)
    `LMSAF_ASSERT_NXT(a_cfg_written, aclk, aresetn, cfg_valid && cfg_ready, mu_shift_reg == $past(cfg_data))

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the LMS adaptive FIR (lms_adaptive_fir).
// A bit-exact filter and weight update model in the bench predicts every output item.
// It depends on lmsaf_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;
    import lmsaf_pkg::*;

    localparam int TAPS             = 256;
    localparam int WEIGHT_FRAC_BITS = 32;
    localparam int STALL_LIMIT      = 20000;
    localparam int HOLD_OFF_CYCLES  = 3000;
    localparam int DRAIN_CYCLES     = 2 * TAPS + 64;
    localparam int CHUNK_ITEMS      = 85;

    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;
    localparam longint W_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint W_MIN   = -W_MAX - 1;

    // One output item: error_value and filter_output as the block packs them.
    typedef struct packed {
        logic signed [OUT_W-1:0] error_value;
        logic signed [OUT_W-1:0] filter_output;
    } fir_output_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // desired_sample [15:0], reference_sample [31:16]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;            // filter_output [31:0], error_value [63:32]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data  = '0;     // mu_shift

    // Bench copy of the filter state and the step size register.
    logic signed [WEIGHT_W-1:0] tap_weight  [TAPS];
    logic signed [SAMPLE_W-1:0] ref_history [TAPS];
    logic [MU_W-1:0]            step_shift;

    fir_output_t predicted_outputs[$];
    fir_output_t oldest_output;

    int error_count      = 0;
    int quiet_cycles     = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    bit hold_off_request = 1'b0;

    lms_adaptive_fir #(
        .TAPS             (TAPS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // One LMS step: filter sum over the taps, error, then weight update and delay shift.
    function automatic fir_output_t lms_filter_step(input logic signed [SAMPLE_W-1:0] desired,
                                                    input logic signed [SAMPLE_W-1:0] reference);
        logic signed [127:0] tap_sum;
        logic signed [127:0] sum_int;
        longint              y_int;
        longint              err_wide;
        longint              err_int;
        longint              delta;
        longint              w_next;
        int                  i;
        fir_output_t         res;
        ref_history[0] = reference;
        tap_sum = '0;
        for (i = 0; i < TAPS; i++) begin
            tap_sum = tap_sum + tap_weight[i] * ref_history[i];
        end
        // Integer part by floor, then saturate to the output width.
        sum_int = tap_sum >>> WEIGHT_FRAC_BITS;
        if (sum_int > OUT_MAX) begin
            y_int = OUT_MAX;
        end else if (sum_int < OUT_MIN) begin
            y_int = OUT_MIN;
        end else begin
            y_int = longint'(sum_int);
        end
        err_wide = longint'(desired) - y_int;
        if (err_wide > OUT_MAX) begin
            err_int = OUT_MAX;
        end else if (err_wide < OUT_MIN) begin
            err_int = OUT_MIN;
        end else begin
            err_int = err_wide;
        end
        // Every weight gains the shifted error-times-tap product, saturated to 48 bits.
        for (i = 0; i < TAPS; i++) begin
            delta  = (err_int * ref_history[i]) >>> step_shift;
            w_next = tap_weight[i] + delta;
            if (w_next > W_MAX) begin
                w_next = W_MAX;
            end else if (w_next < W_MIN) begin
                w_next = W_MIN;
            end
            tap_weight[i] = w_next[WEIGHT_W-1:0];
        end
        for (i = TAPS - 1; i > 0; i--) begin
            ref_history[i] = ref_history[i-1];
        end
        res.filter_output = y_int[OUT_W-1:0];
        res.error_value   = err_int[OUT_W-1:0];
        return res;
    endfunction

    // Offer one item, honouring the sender's idle rate, and predict its output once taken.
    task automatic send_samples(input logic signed [SAMPLE_W-1:0] desired,
                                input logic signed [SAMPLE_W-1:0] reference);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(700, 1)) @(negedge aclk);
            end else begin
                repeat ($urandom_range(4, 1)) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {reference, desired};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted_outputs.push_back(lms_filter_step(desired, reference));
        @(negedge aclk);
    endtask

    // Stop offering and wait until every predicted output item has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (predicted_outputs.size() != 0) @(negedge aclk);
    endtask

    // Step size write; only called while the block is idle.
    task automatic write_step_shift(input logic [MU_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        step_shift = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Extremes and alternating patterns of both samples under the reset step size.
    task automatic test_field_extremes();
        send_samples(16'sh0000, 16'sh0000);
        send_samples(16'sh7FFF, 16'sh7FFF);
        send_samples(16'sh8000, 16'sh8000);
        send_samples(16'shFFFF, 16'shFFFF);
        send_samples(16'sh7FFF, 16'sh8000);
        send_samples(16'sh8000, 16'sh7FFF);
        send_samples(16'sh5555, 16'shAAAA);
        send_samples(16'shAAAA, 16'sh5555);
    endtask

    // Largest shift floors negative products to minus one; zero shift takes them whole.
    task automatic test_step_size_extremes();
        wait_drained();
        write_step_shift(6'd63);
        send_samples(-16'sd20000, 16'sd30000);
        send_samples(16'sd20000, -16'sd30000);
        send_samples(-16'sd1, 16'sd1);
        send_samples(16'sd5, 16'sd7);
        wait_drained();
        write_step_shift(6'd0);
        send_samples(-16'sd100, 16'sd3);
        send_samples(16'sd100, -16'sd3);
        send_samples(16'sd7, 16'sd2);
        send_samples(-16'sd9, -16'sd1);
    endtask

    // System identification: the reference drives a short fixed plant whose output,
    // plus a little noise, is the desired sample. A tenth of the items are pure noise.
    task automatic test_system_identification(input int sender_pct, input int receiver_pct,
                                              input int chunk_count, input bit with_hold_off);
        int                         plant_state [6];
        int                         target;
        int                         amp_shift;
        int                         chunk;
        int                         n;
        int                         k;
        logic signed [SAMPLE_W-1:0] reference;
        logic signed [SAMPLE_W-1:0] desired;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (k = 0; k < 6; k++) plant_state[k] = 0;
        amp_shift = 0;
        for (chunk = 0; chunk < chunk_count; chunk++) begin
            wait_drained();
            write_step_shift(MU_W'($urandom_range(24, 4)));
            if (with_hold_off && chunk == 1) begin
                hold_off_request = 1'b1;
            end
            for (n = 0; n < CHUNK_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    amp_shift = $urandom_range(10, 0);
                end
                if ($urandom_range(9) == 0) begin
                    reference = $signed(16'($urandom));
                    desired   = $signed(16'($urandom));
                end else begin
                    reference = $signed(16'($urandom)) >>> amp_shift;
                    for (k = 5; k > 0; k--) plant_state[k] = plant_state[k-1];
                    plant_state[0] = reference;
                    target = (plant_state[0] >>> 1) - (plant_state[1] >>> 2)
                           + (plant_state[2] >>> 3) + (plant_state[5] >>> 4)
                           + int'($urandom_range(16)) - 8;
                    if (target > 32767) begin
                        target = 32767;
                    end else if (target < -32768) begin
                        target = -32768;
                    end
                    desired = target[SAMPLE_W-1:0];
                end
                send_samples(desired, reference);
            end
        end
    endtask

    // Zero shift with full-scale input makes the filter diverge: output, error and
    // weights saturate, and the tap sum grows past 64 bits.
    task automatic test_weight_saturation();
        int n;
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step_shift(6'd0);
        for (n = 0; n < 24; n++) begin
            send_samples(n[0] ? 16'sh8000 : 16'sh7FFF, 16'sh7FFF);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each output item with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_outputs.size() == 0) begin
                $display("%0t: output item with none expected: filter_output %0d error_value %0d",
                         $time, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                error_count++;
            end else begin
                oldest_output = predicted_outputs.pop_front();
                if (m_tdata[31:0] !== oldest_output.filter_output) begin
                    $display("%0t: filter_output mismatch: expected %0d, actual %0d", $time,
                             oldest_output.filter_output, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[63:32] !== oldest_output.error_value) begin
                    $display("%0t: error_value mismatch: expected %0d, actual %0d", $time,
                             oldest_output.error_value, $signed(m_tdata[63:32]));
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int i;
        for (i = 0; i < TAPS; i++) begin
            tap_weight[i]  = '0;
            ref_history[i] = '0;
        end
        step_shift = MU_RESET;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_step_size_extremes();
        test_system_identification(34, 78, 4, 1'b0);
        test_system_identification(78, 34, 4, 1'b0);
        test_system_identification(0, 0, 4, 1'b1);
        test_weight_saturation();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
